// ===== hw/rtl/level_probe_relay_controller_unit_macros.svh =====
// Assertion macros shared by the relay controller modules.
// Each macro reports a failed check by $error and is empty in synthesis.
`ifndef LEVEL_PROBE_RELAY_CONTROLLER_UNIT_MACROS_SVH
`define LEVEL_PROBE_RELAY_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LPRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lprc assertion failed");

// Next-cycle implication.
`define LPRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lprc assertion failed");

`else

`define LPRC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define LPRC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/lprc_pkg.sv =====
package lprc_pkg;

    localparam int PROBE_COUNT = 4;
    localparam int TIMER_BITS  = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int MODE_W      = 4;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int LANE_IDX_W  = $clog2(PROBE_COUNT);

    // Mode codes, written to the mode register
    localparam logic [MODE_W-1:0] MODE_TEST         = 4'd0;
    localparam logic [MODE_W-1:0] MODE_BASE         = 4'd1;
    localparam logic [MODE_W-1:0] MODE_TRIGGER      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_TIMED        = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TRIGGER_BASE = 4'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INHIBIT = 3'd4;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [LANE_IDX_W-1:0] lane_idx_t;

    typedef enum logic [2:0] {
        ROLE_HOLD,
        ROLE_TEST,
        ROLE_BASE,
        ROLE_TRIG_LO,
        ROLE_TRIG_HI,
        ROLE_TIMED
    } lane_role_t;

    typedef enum logic [1:0] {
        PH_OPEN    = 2'd0,
        PH_CLOSED  = 2'd1,
        PH_INHIBIT = 2'd2
    } phase_t;

    // Timer load values, already fitted to the timer width
    typedef struct packed {
        timer_t follow;
        timer_t trigger;
        timer_t on_load;
        timer_t inhibit;
    } delays_t;

    // Per-lane control for one request
    typedef struct packed {
        lane_role_t role;
        logic       accept;
        logic       tick;
        logic       wet;
        logic       partner_wet;
    } lane_ctrl_t;

    // Saturate a register value to the timer width
    function automatic timer_t load_value(logic [CFG_W-1:0] v);
        timer_t res;
        if ((v >> TIMER_BITS) != '0) begin
            res = '1;
        end else begin
            res = timer_t'(v);
        end
        return res;
    endfunction

    function automatic logic mode_defined(logic [MODE_W-1:0] mode);
        return (mode == MODE_TEST) || (mode == MODE_BASE) || (mode == MODE_TRIGGER)
            || (mode == MODE_TIMED) || (mode == MODE_TRIGGER_BASE);
    endfunction

    // Role of a lane under a mode; pairs are lanes (0,1) and (2,3)
    function automatic lane_role_t lane_role(logic [MODE_W-1:0] mode, lane_idx_t idx);
        lane_role_t role;
        case (mode)
            MODE_TEST:    role = ROLE_TEST;
            MODE_BASE:    role = ROLE_BASE;
            MODE_TRIGGER: role = idx[0] ? ROLE_TRIG_HI : ROLE_TRIG_LO;
            MODE_TIMED:   role = ROLE_TIMED;
            MODE_TRIGGER_BASE: begin
                if (idx[LANE_IDX_W-1]) begin
                    role = ROLE_BASE;
                end else begin
                    role = idx[0] ? ROLE_TRIG_HI : ROLE_TRIG_LO;
                end
            end
            default:      role = ROLE_HOLD;
        endcase
        return role;
    endfunction

endpackage

// ===== hw/rtl/level_probe_relay_controller_unit.sv =====
// Level probe relay controller. Each request on the s_ side is one evaluation
// of four probe levels plus a tick flag; it yields exactly one result on the
// m_ side, held in the output register or its skid entry. Four probe lanes
// update side by side, so a request can be taken on every clock; a
// two-entry output queue lets requests keep flowing while one result waits,
// and s_tready drops only when both entries are full. Configuration writes
// take effect on the next clock and belong in idle periods.
module level_probe_relay_controller_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [3:0] probe_levels, [4] tick, [7:5] zero
    input  logic [lprc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] relay_mask, [7:4] led_mask, [8] probe_alarm, [9] config_alarm,
    // [15:10] zero
    output logic [lprc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [lprc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lprc_pkg::CFG_W-1:0]         cfg_wdata
);
    import lprc_pkg::*;

    logic [MODE_W-1:0]      mode;
    delays_t                delays;
    logic                   in_accept;
    logic [PROBE_COUNT-1:0] probe_levels;
    logic                   tick;
    logic [PROBE_COUNT-1:0] timer_zero;
    logic [PROBE_COUNT-1:0] relay_next;

    assign in_accept    = s_tvalid && s_tready;
    assign probe_levels = s_tdata[PROBE_COUNT-1:0];
    assign tick         = s_tdata[PROBE_COUNT];

    lprc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .mode      (mode),
        .delays    (delays)
    );

    // One lane per probe; a lane's partner is the other probe of its pair
    for (genvar g = 0; g < PROBE_COUNT; g++) begin : g_lane
        lane_ctrl_t ctrl;
        logic       pair_zero;

        assign ctrl.role        = lane_role(mode, lane_idx_t'(g));
        assign ctrl.accept      = in_accept;
        assign ctrl.tick        = tick;
        assign ctrl.wet         = probe_levels[g];
        assign ctrl.partner_wet = probe_levels[g ^ 1];
        // The pair's shared timer lives in the high lane
        assign pair_zero = (ctrl.role == ROLE_TRIG_LO) ? timer_zero[g ^ 1] : timer_zero[g];

        lprc_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .delays     (delays),
            .pair_zero  (pair_zero),
            .timer_zero (timer_zero[g]),
            .relay_next (relay_next[g])
        );
    end

    lprc_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .probe_levels (probe_levels),
        .mode         (mode),
        .relay_next   (relay_next),
        .in_ready     (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== hw/rtl/lprc_cfg.sv =====
module lprc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lprc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lprc_pkg::CFG_W-1:0]       cfg_wdata,
    output logic [lprc_pkg::MODE_W-1:0]      mode,
    output lprc_pkg::delays_t                delays
);
    import lprc_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [CFG_W-1:0]  follow_reg;
    logic [CFG_W-1:0]  trigger_reg;
    logic [CFG_W-1:0]  on_reg;
    logic [CFG_W-1:0]  inhibit_reg;

    // Write registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_TEST;
            follow_reg  <= CFG_W'(15);
            trigger_reg <= CFG_W'(15);
            on_reg      <= CFG_W'(50);
            inhibit_reg <= CFG_W'(600);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_wdata[MODE_W-1:0];
                REG_FOLLOW:  follow_reg  <= cfg_wdata;
                REG_TRIGGER: trigger_reg <= cfg_wdata;
                REG_ON:      on_reg      <= cfg_wdata;
                REG_INHIBIT: inhibit_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Fit the delays to the timer width
    assign mode            = mode_reg;
    assign delays.follow   = load_value(follow_reg);
    assign delays.trigger  = load_value(trigger_reg);
    assign delays.on_load  = load_value(on_reg);
    assign delays.inhibit  = load_value(inhibit_reg);

endmodule

// ===== hw/rtl/lprc_lane.sv =====
`include "level_probe_relay_controller_unit_macros.svh"

module lprc_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lprc_pkg::lane_ctrl_t ctrl,
    input  lprc_pkg::delays_t    delays,
    input  logic                 pair_zero,
    output logic                 timer_zero,
    output logic                 relay_next
);
    import lprc_pkg::*;

    timer_t dt_reg, dt_next;
    timer_t it_reg, it_next;
    logic   last_reg, last_next;
    phase_t phase_reg, phase_next;
    logic   relay_reg;

    timer_t dt_tick, it_tick, dt_open;
    phase_t ph_cur;
    logic   reopen;
    logic   wl, wh;
    logic   base_clear, base_set, timed_close;

    // Tick the timers down, stopping at zero
    assign dt_tick = (ctrl.tick && dt_reg != '0) ? dt_reg - timer_t'(1) : dt_reg;
    assign it_tick = (ctrl.tick && it_reg != '0) ? it_reg - timer_t'(1) : it_reg;
    assign timer_zero = (dt_tick == '0);

    // Inhibit period over: back to open with a fresh on-delay
    assign reopen  = (ctrl.role == ROLE_TIMED) && (phase_reg == PH_INHIBIT)
                     && (it_tick == '0);
    assign ph_cur  = reopen ? PH_OPEN : phase_reg;
    assign dt_open = reopen ? delays.on_load : dt_tick;

    assign timed_close = ctrl.wet && (dt_open == '0) && (it_tick == '0);
    assign base_clear  = !ctrl.wet && (!last_reg || dt_tick == '0);
    assign base_set    = ctrl.wet && (dt_tick == '0 || last_reg);

    // Low and high probe of the pair as seen from this lane
    assign wl = (ctrl.role == ROLE_TRIG_LO) ? ctrl.wet : ctrl.partner_wet;
    assign wh = (ctrl.role == ROLE_TRIG_LO) ? ctrl.partner_wet : ctrl.wet;

    // Timed phase next state
    always_comb begin
        phase_next = phase_reg;
        if (ctrl.role == ROLE_TIMED) begin
            phase_next = ph_cur;
            if (!ctrl.wet) begin
                if (ph_cur == PH_CLOSED) begin
                    phase_next = PH_INHIBIT;
                end
            end else if (timed_close) begin
                phase_next = PH_CLOSED;
            end
        end
    end

    // Relay, timers and level memory
    always_comb begin
        relay_next = relay_reg;
        dt_next    = dt_tick;
        it_next    = it_tick;
        last_next  = last_reg;
        case (ctrl.role)
            ROLE_TEST: begin
                relay_next = ctrl.wet;
            end
            ROLE_BASE: begin
                if (base_clear) begin
                    relay_next = 1'b0;
                    last_next  = 1'b0;
                    dt_next    = delays.follow;
                end else if (base_set) begin
                    relay_next = 1'b1;
                    last_next  = 1'b1;
                    dt_next    = delays.follow;
                end
            end
            ROLE_TRIG_LO, ROLE_TRIG_HI: begin
                if (wh) begin
                    relay_next = 1'b0;
                end else if (!wl && pair_zero) begin
                    relay_next = 1'b1;
                end
                if (ctrl.role == ROLE_TRIG_HI && (wl || wh)) begin
                    dt_next = delays.trigger;
                end
            end
            ROLE_TIMED: begin
                dt_next = dt_open;
                if (!ctrl.wet) begin
                    relay_next = 1'b0;
                    dt_next    = delays.on_load;
                    if (ph_cur == PH_CLOSED) begin
                        it_next = delays.inhibit;
                    end
                end else if (timed_close) begin
                    relay_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Advance lane state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg    <= '0;
            it_reg    <= '0;
            last_reg  <= 1'b0;
            phase_reg <= PH_OPEN;
            relay_reg <= 1'b0;
        end else if (ctrl.accept) begin
            dt_reg    <= dt_next;
            it_reg    <= it_next;
            last_reg  <= last_next;
            phase_reg <= phase_next;
            relay_reg <= relay_next;
        end
    end

    `LPRC_ASSERT_NEXT(a_lane_idle_hold, aclk, aresetn, !ctrl.accept,
        $stable(dt_reg) && $stable(it_reg))
    `LPRC_ASSERT_NEXT(a_timed_close_sets, aclk, aresetn,
        ctrl.accept && ctrl.role == ROLE_TIMED && timed_close, relay_reg)
    `LPRC_ASSERT_NEXT(a_hold_role_keeps, aclk, aresetn, ctrl.accept && ctrl.role == ROLE_HOLD,
        $stable(relay_reg) && $stable(phase_reg))

endmodule

// ===== hw/rtl/lprc_merge.sv =====
`include "level_probe_relay_controller_unit_macros.svh"

module lprc_merge (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_accept,
    input  logic [lprc_pkg::PROBE_COUNT-1:0]   probe_levels,
    input  logic [lprc_pkg::MODE_W-1:0]        mode,
    input  logic [lprc_pkg::PROBE_COUNT-1:0]   relay_next,
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lprc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lprc_pkg::*;

    localparam int PAD_W = M_TDATA_W - 2 * PROBE_COUNT - 2;

    logic                   probe_alarm_reg, probe_alarm_next;
    logic                   config_alarm_reg, config_alarm_next;
    logic [1:0]             count_reg, count_next;
    logic [M_TDATA_W-1:0]   out_reg, out_next;
    logic [M_TDATA_W-1:0]   skid_reg, skid_next;
    logic [M_TDATA_W-1:0]   result;
    logic                   fault_lo, fault_hi, pop;

    // Pair fault: low probe dry while high probe wet
    assign fault_lo = !probe_levels[0] && probe_levels[1];
    assign fault_hi = !probe_levels[2] && probe_levels[3];

    // Alarm updates
    always_comb begin
        probe_alarm_next  = probe_alarm_reg;
        config_alarm_next = config_alarm_reg;
        case (mode)
            MODE_TRIGGER:      probe_alarm_next = fault_lo || fault_hi;
            MODE_TRIGGER_BASE: probe_alarm_next = fault_lo;
            default:           ;
        endcase
        if (!mode_defined(mode)) begin
            config_alarm_next = 1'b1;
        end
    end

    assign result = {PAD_W'(0), config_alarm_next, probe_alarm_next, relay_next, relay_next};

    // Two-entry result queue: output register plus skid
    assign pop      = m_tvalid && m_tready;
    assign in_ready = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = out_reg;

    always_comb begin
        count_next = count_reg;
        out_next   = out_reg;
        skid_next  = skid_reg;
        case (count_reg)
            2'd0: begin
                if (in_accept) begin
                    out_next   = result;
                    count_next = 2'd1;
                end
            end
            2'd1: begin
                if (pop && in_accept) begin
                    out_next = result;
                end else if (in_accept) begin
                    skid_next  = result;
                    count_next = 2'd2;
                end else if (pop) begin
                    count_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    out_next   = skid_reg;
                    count_next = 2'd1;
                end
            end
            default: count_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= 2'd0;
            probe_alarm_reg  <= 1'b0;
            config_alarm_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_accept) begin
                probe_alarm_reg  <= probe_alarm_next;
                config_alarm_reg <= config_alarm_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `LPRC_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, count_reg != 2'd3)
    `LPRC_ASSERT_NEXT(a_config_sticky, aclk, aresetn, config_alarm_reg, config_alarm_reg)
    `LPRC_ASSERT_NEXT(a_request_gives_result, aclk, aresetn, in_accept, m_tvalid)

endmodule
